/* rtl/core/ba_pkg.sv */
// ----------------------------------------------------------------------------
// ba_pkg
// Shared types, sizes and index tables for the buddy allocator.
// ----------------------------------------------------------------------------
package ba_pkg;

  localparam int POOL_UNITS = 512;
  localparam int NUM_ORDERS = 10;
  localparam int TOP_ORDER  = NUM_ORDERS - 1;
  localparam int ADDR_W     = $clog2(POOL_UNITS);
  localparam int ORD_W      = 4;
  localparam int WORD_W     = 32;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int OIDX_W     = $clog2(NUM_ORDERS);

  // rows of WORD_W marks that hold one order
  function automatic int rows_at(int k);
    return ((POOL_UNITS >> k) + WORD_W - 1) >> BIT_W;
  endfunction

  function automatic int total_rows();
    int acc;
    acc = 0;
    for (int j = 0; j < NUM_ORDERS; j++) acc += rows_at(j);
    return acc;
  endfunction

  localparam int NUM_ROWS = total_rows();
  localparam int ROW_W    = $clog2(NUM_ROWS);

  typedef logic [NUM_ORDERS-1:0][ROW_W-1:0] row_tab_t;

  function automatic row_tab_t mk_base();
    row_tab_t t;
    int acc;
    acc = 0;
    for (int j = 0; j < NUM_ORDERS; j++) begin
      t[j] = ROW_W'(acc);
      acc += rows_at(j);
    end
    return t;
  endfunction

  function automatic row_tab_t mk_cnt();
    row_tab_t t;
    for (int j = 0; j < NUM_ORDERS; j++) t[j] = ROW_W'(rows_at(j));
    return t;
  endfunction

  localparam row_tab_t ROW_BASE = mk_base();
  localparam row_tab_t ROW_CNT  = mk_cnt();
  localparam logic [ROW_W-1:0] TOP_ROW = ROW_BASE[TOP_ORDER];

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_NOT_ALLOC = 2'd2
  } status_t;

  typedef enum logic {
    CMD_REQ  = 1'b0,
    CMD_FREE = 1'b1
  } cmd_t;

  // one access to the mark rows: read always, write per enable
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic              fwe;
    logic              awe;
    logic [WORD_W-1:0] wdata;
  } mark_req_t;

  function automatic logic [ROW_W-1:0] row_of(logic [ORD_W-1:0] k, logic [ADDR_W-1:0] b);
    logic [ROW_W-1:0] base;
    base = (k <= ORD_W'(TOP_ORDER)) ? ROW_BASE[k[OIDX_W-1:0]] : '0;
    return base + ROW_W'(b >> BIT_W);
  endfunction

endpackage

/* rtl/core/buddy_allocator_top.sv */
// ----------------------------------------------------------------------------
// buddy_allocator_top
// Buddy allocator over a 512-unit pool, block orders 0 to 9.
// ----------------------------------------------------------------------------
//  channel  ports                                 handshake
//  input    in_cmd, in_order, in_address          start && !busy
//  result   out_status, out_start_res             out_valid, one cycle
//
//  One word at a time; busy drops in the cycle that shows the result strobe.
//  Each mark access goes through the single registered row port as a wait
//  state and an update state: a request scans 32-mark rows (up to 36 rows),
//  splits and sets the allocated mark; a free checks and clears the allocated mark,
//  checks buddies (up to 9) and marks the merged block free, or ends once the
//  block is found not allocated. A word refused on its order or alignment
//  never raises busy. The strobe follows the last update state.
//  Reset is synchronous; no clearing pass, row valid bits restore contents.
//  The receiver cannot stall: the result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module buddy_allocator_top
  import ba_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_cmd,
  input  logic [ORD_W-1:0]  in_order,
  input  logic [ADDR_W-1:0] in_address,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [ADDR_W-1:0] out_start_res
);

  mark_req_t         req;
  logic [WORD_W-1:0] free_rd, alloc_rd;

  // sequencer: drives the shared row port and holds the result word
  ba_seq u_seq (
    .clk, .rst_n, .start,
    .cmd(in_cmd), .order(in_order), .address(in_address),
    .busy, .req, .free_rd, .alloc_rd,
    .out_valid, .out_status, .out_start_res
  );

  // mark rows: free and allocated, one word per access
  ba_marks u_marks (
    .clk, .rst_n, .req, .free_rd, .alloc_rd
  );

endmodule

/* rtl/core/ba_marks.sv */
// ----------------------------------------------------------------------------
// ba_marks
// Free and allocated mark rows, one word per row, registered read.
// ----------------------------------------------------------------------------
module ba_marks
  import ba_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  mark_req_t         req,
  output logic [WORD_W-1:0] free_rd,
  output logic [WORD_W-1:0] alloc_rd
);

  logic [WORD_W-1:0] free_mem  [NUM_ROWS];
  logic [WORD_W-1:0] alloc_mem [NUM_ROWS];
  logic [NUM_ROWS-1:0] fval_r, aval_r;
  logic [WORD_W-1:0] free_q, alloc_q;
  logic              fv_q, av_q;
  logic [ROW_W-1:0]  row_q;

  always_ff @(posedge clk) begin
    if (req.fwe) free_mem[req.row] <= req.wdata;
    if (req.awe) alloc_mem[req.row] <= req.wdata;
    free_q  <= free_mem[req.row];
    alloc_q <= alloc_mem[req.row];
    row_q   <= req.row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fval_r <= '0;
      aval_r <= '0;
      fv_q   <= 1'b0;
      av_q   <= 1'b0;
    end else begin
      if (req.fwe) fval_r[req.row] <= 1'b1;
      if (req.awe) aval_r[req.row] <= 1'b1;
      fv_q <= fval_r[req.row];
      av_q <= aval_r[req.row];
    end
  end

  // unwritten rows read as reset contents: only the whole pool is free
  assign free_rd  = fv_q ? free_q : ((row_q == TOP_ROW) ? WORD_W'(1) : '0);
  assign alloc_rd = av_q ? alloc_q : '0;

endmodule

/* rtl/core/ba_seq.sv */
// ----------------------------------------------------------------------------
// ba_seq
// Sequencer: row search, split, free and merge over the shared mark port.
// ----------------------------------------------------------------------------
module ba_seq
  import ba_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              cmd,
  input  logic [ORD_W-1:0]  order,
  input  logic [ADDR_W-1:0] address,
  output logic              busy,
  output mark_req_t         req,
  input  logic [WORD_W-1:0] free_rd,
  input  logic [WORD_W-1:0] alloc_rd,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [ADDR_W-1:0] out_start_res
);

  typedef enum logic [3:0] {
    IDLE, S_SRD, S_SCHK, S_SPW, S_SPU, S_AW, S_AU,
    F_AW, F_AU, M_W, M_U, F_SW, F_SU
  } state_t;

  state_t state_r, state_nxt;
  logic [ORD_W-1:0]  ord_r, ord_nxt, k_r, k_nxt;
  logic [ADDR_W-1:0] b_r, b_nxt;
  logic [ROW_W-1:0]  row_r;
  logic              val_r, val_nxt;
  status_t           st_r, st_nxt;
  logic [ADDR_W-1:0] res_r, res_nxt;
  logic [WORD_W-1:0] bit_oh, rd_sel;
  logic [BIT_W-1:0]  pos;
  logic [ADDR_W-1:0] b_f, amask;

  assign bit_oh = WORD_W'(1) << b_r[BIT_W-1:0];
  assign rd_sel = (state_r == F_AU) ? alloc_rd : free_rd;
  assign amask  = ~({ADDR_W{1'b1}} << order);

  always_comb begin
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free_rd[i]) pos = BIT_W'(i);
    end
  end
  assign b_f = b_r | ADDR_W'(pos);

  always_comb begin
    state_nxt = state_r;
    ord_nxt   = ord_r;
    k_nxt     = k_r;
    b_nxt     = b_r;
    val_nxt   = 1'b0;
    st_nxt    = st_r;
    res_nxt   = res_r;
    req.row   = row_r;
    req.fwe   = 1'b0;
    req.awe   = 1'b0;
    req.wdata = rd_sel | bit_oh;
    unique case (state_r)
      IDLE: begin
        if (start) begin
          ord_nxt = order;
          k_nxt   = order;
          st_nxt  = ST_OK;
          res_nxt = '0;
          if (cmd == CMD_REQ) begin
            b_nxt = '0;
            if (order > ORD_W'(TOP_ORDER)) begin
              val_nxt = 1'b1;
              st_nxt  = ST_NO_SPACE;
            end else begin
              state_nxt = S_SRD;
            end
          end else begin
            b_nxt = address >> order;
            if (order > ORD_W'(TOP_ORDER) || (address & amask) != '0) begin
              val_nxt = 1'b1;
              st_nxt  = ST_NOT_ALLOC;
            end else begin
              state_nxt = F_AW;
            end
          end
        end
      end
      S_SRD: state_nxt = S_SCHK;
      S_SCHK: begin
        if (free_rd != '0) begin
          req.fwe   = 1'b1;
          req.wdata = free_rd & ~(WORD_W'(1) << pos);
          if (k_r > ord_r) begin
            k_nxt     = k_r - 1'b1;
            b_nxt     = (b_f << 1) | ADDR_W'(1);
            state_nxt = S_SPW;
          end else begin
            b_nxt     = b_f;
            state_nxt = S_AW;
          end
        end else if (ROW_W'(b_r >> BIT_W) + 1'b1 != ROW_CNT[k_r[OIDX_W-1:0]]) begin
          b_nxt     = b_r + ADDR_W'(WORD_W);
          state_nxt = S_SRD;
        end else if (k_r < ORD_W'(TOP_ORDER)) begin
          k_nxt     = k_r + 1'b1;
          b_nxt     = '0;
          state_nxt = S_SRD;
        end else begin
          val_nxt   = 1'b1;
          st_nxt    = ST_NO_SPACE;
          state_nxt = IDLE;
        end
      end
      S_SPW: state_nxt = S_SPU;
      S_SPU: begin
        req.fwe = 1'b1;
        if (k_r > ord_r) begin
          k_nxt     = k_r - 1'b1;
          b_nxt     = ((b_r & ~ADDR_W'(1)) << 1) | ADDR_W'(1);
          state_nxt = S_SPW;
        end else begin
          b_nxt     = b_r & ~ADDR_W'(1);
          state_nxt = S_AW;
        end
      end
      S_AW: state_nxt = S_AU;
      S_AU: begin
        req.awe   = 1'b1;
        req.wdata = alloc_rd | bit_oh;
        val_nxt   = 1'b1;
        st_nxt    = ST_OK;
        res_nxt   = b_r << ord_r;
        state_nxt = IDLE;
      end
      F_AW: state_nxt = F_AU;
      F_AU: begin
        if ((alloc_rd & bit_oh) == '0) begin
          val_nxt   = 1'b1;
          st_nxt    = ST_NOT_ALLOC;
          state_nxt = IDLE;
        end else begin
          req.awe   = 1'b1;
          req.wdata = alloc_rd & ~bit_oh;
          if (k_r < ORD_W'(TOP_ORDER)) begin
            b_nxt     = b_r ^ ADDR_W'(1);
            state_nxt = M_W;
          end else begin
            state_nxt = F_SW;
          end
        end
      end
      M_W: state_nxt = M_U;
      M_U: begin
        if ((free_rd & bit_oh) != '0) begin
          req.fwe   = 1'b1;
          req.wdata = free_rd & ~bit_oh;
          k_nxt     = k_r + 1'b1;
          if (k_r + 1'b1 < ORD_W'(TOP_ORDER)) begin
            b_nxt     = (b_r >> 1) ^ ADDR_W'(1);
            state_nxt = M_W;
          end else begin
            b_nxt     = b_r >> 1;
            state_nxt = F_SW;
          end
        end else begin
          b_nxt     = b_r ^ ADDR_W'(1);
          state_nxt = F_SW;
        end
      end
      F_SW: state_nxt = F_SU;
      F_SU: begin
        req.fwe   = 1'b1;
        val_nxt   = 1'b1;
        st_nxt    = ST_OK;
        state_nxt = IDLE;
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
      val_r   <= 1'b0;
      st_r    <= ST_OK;
      res_r   <= '0;
    end else begin
      state_r <= state_nxt;
      val_r   <= val_nxt;
      st_r    <= st_nxt;
      res_r   <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ord_r <= ord_nxt;
    k_r   <= k_nxt;
    b_r   <= b_nxt;
    row_r <= row_of(k_nxt, b_nxt);
  end

  assign busy          = (state_r != IDLE);
  assign out_valid     = val_r;
  assign out_status    = st_r;
  assign out_start_res = res_r;

endmodule

/* rtl/core/ba_checker.sv */
// ----------------------------------------------------------------------------
// ba_checker
// Port-level checks of the buddy allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ba_checker
  import ba_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [1:0]        out_status,
  input logic [ADDR_W-1:0] out_start_res
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid) else $error("accept did not raise busy");

  a_no_double: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !(start && !busy) |=> !out_valid) else $error("result strobe held");

  a_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(start) |-> $past(busy)) else $error("result without work");

  a_zero_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_start_res == '0)
    else $error("failed word carries a start");

endmodule

bind buddy_allocator_top ba_checker u_chk (
  .clk, .rst_n, .start, .busy, .out_valid, .out_status, .out_start_res
);
